/* design/debounced_pulse_period_meter_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the debounced pulse period meter
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_PULSE_PERIOD_METER_MACROS_SVH
`define DEBOUNCED_PULSE_PERIOD_METER_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge out of reset.
`define DPM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("dpm: invariant violated");

// When pre holds, post must hold at the same edge.
`define DPM_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("dpm: implication violated");

// When pre holds, post must hold at the next edge.
`define DPM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dpm: next-cycle check violated");

`else

`define DPM_ASSERT_ALWAYS(lbl, cond)
`define DPM_ASSERT_IMPLY(lbl, pre, post)
`define DPM_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

/* design/dpm_pkg.sv */
// ----------------------------------------------------------------------------
// dpm_pkg
// Types and constants shared by the debounced pulse period meter modules.
// ----------------------------------------------------------------------------
package dpm_pkg;

  // Timestamps and time differences are 32-bit values that wrap.
  localparam int TIME_BITS   = 32;
  localparam int COUNT_BITS  = 32;
  localparam int PERIOD_MS_W = 23;

  localparam logic [TIME_BITS-1:0] FILTER_RESET  = TIME_BITS'(100000);
  localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = TIME_BITS'(300000000);

  // Division by 1000 as a multiplication by ceil(2^38 / 1000) and a shift.
  // The error term is small enough to give an exact quotient for any
  // 32-bit dividend.
  localparam int MS_MAGIC_W = 29;
  localparam int MS_SHIFT   = 38;
  localparam int MS_PROD_W  = TIME_BITS + MS_MAGIC_W;
  localparam logic [MS_MAGIC_W-1:0] MS_MAGIC = MS_MAGIC_W'(274877907);

  localparam int CFG_IDX_W = 1;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER  = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_idx_t;

  // Result of the tracking stage for one item.
  typedef struct packed {
    logic                   is_tick;
    logic                   edge_accepted;
    logic                   timed_out;
    logic [TIME_BITS-1:0]   period_us;
    logic [COUNT_BITS-1:0]  pulse_total;
    logic                   total_changed;
  } track_res_t;

endpackage

/* design/dpm_track.sv */
// ----------------------------------------------------------------------------
// dpm_track
// Edge filter, pulse counter, period capture and timeout for one item.
// ----------------------------------------------------------------------------
module dpm_track (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  logic                           is_tick,
  input  logic                           pin_level,
  input  logic [dpm_pkg::TIME_BITS-1:0]  time_us,
  input  logic [dpm_pkg::TIME_BITS-1:0]  filter_time_us,
  input  logic [dpm_pkg::TIME_BITS-1:0]  timeout_time_us,
  output dpm_pkg::track_res_t            res
);

  logic [dpm_pkg::TIME_BITS-1:0]  last_detected_r, last_detected_nxt;
  logic [dpm_pkg::TIME_BITS-1:0]  last_valid_r, last_valid_nxt;
  logic [dpm_pkg::TIME_BITS-1:0]  period_r, period_nxt;
  logic [dpm_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic [dpm_pkg::COUNT_BITS-1:0] reported_total_r, reported_total_nxt;
  logic                           total_once_r, total_once_nxt;

  logic [dpm_pkg::TIME_BITS-1:0]  detect_gap;
  logic [dpm_pkg::TIME_BITS-1:0]  valid_gap;
  logic                           rising;
  logic                           accepted;
  logic                           have_valid;
  logic                           timeout_hit;
  logic                           total_chg;

  always_comb begin
    detect_gap  = time_us - last_detected_r;
    valid_gap   = time_us - last_valid_r;
    have_valid  = (last_valid_r != '0);
    rising      = !is_tick && pin_level;
    accepted    = rising && (detect_gap >= filter_time_us);
    timeout_hit = is_tick && have_valid && (valid_gap > timeout_time_us);

    last_detected_nxt = rising ? time_us : last_detected_r;

    if (accepted) begin
      last_valid_nxt = time_us;
    end else if (timeout_hit) begin
      last_valid_nxt = '0;
    end else begin
      last_valid_nxt = last_valid_r;
    end

    if (accepted && have_valid) begin
      period_nxt = valid_gap;
    end else if (timeout_hit) begin
      period_nxt = '0;
    end else begin
      period_nxt = period_r;
    end

    count_nxt = accepted ? count_r + 1'b1 : count_r;

    // Only a tick reports, and a tick never changes the count.
    total_chg          = is_tick && (!total_once_r || (count_r != reported_total_r));
    reported_total_nxt = is_tick ? count_r : reported_total_r;
    total_once_nxt     = total_once_r || is_tick;

    res.is_tick       = is_tick;
    res.edge_accepted = accepted;
    res.timed_out     = timeout_hit;
    res.period_us     = period_nxt;
    res.pulse_total   = count_nxt;
    res.total_changed = total_chg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_detected_r  <= '0;
      last_valid_r     <= '0;
      period_r         <= '0;
      count_r          <= '0;
      reported_total_r <= '0;
      total_once_r     <= 1'b0;
    end else if (take) begin
      last_detected_r  <= last_detected_nxt;
      last_valid_r     <= last_valid_nxt;
      period_r         <= period_nxt;
      count_r          <= count_nxt;
      reported_total_r <= reported_total_nxt;
      total_once_r     <= total_once_nxt;
    end
  end

endmodule

/* design/debounced_pulse_period_meter.sv */
// ----------------------------------------------------------------------------
// debounced_pulse_period_meter
// Filtered rising-edge pulse counter and period meter with timeout and
// change reporting, on stream interfaces.
// ----------------------------------------------------------------------------
// The meter takes one item per clock cycle when the result side keeps up,
// and every item gives exactly one result, held in turn in the middle and
// output registers. The first stage runs the edge filter, pulse counter,
// period capture and timeout test against the tracking registers; the
// second stage converts the period to milliseconds with a single constant
// multiplier and decides whether the reported millisecond period has
// changed. An output register and the middle pipeline register let a new
// item be taken while a finished result still waits on out_tready; in_tready
// falls only when both hold an item and the output is stalled. Configuration
// writes are always taken and should be made while no item is in flight.
// ----------------------------------------------------------------------------
`include "debounced_pulse_period_meter_macros.svh"

module debounced_pulse_period_meter (
  input  logic                           clk,
  input  logic                           rst_n,

  // Input items.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [39:0]                    in_tdata,  // [0] pin_level, [32:1] time_us
  input  logic                           in_tuser,  // [0] opcode

  // Result items.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] edge_accepted, [1] timed_out, [33:2] period_us, [56:34] period_ms,
  // [88:57] pulse_total, [89] period_changed, [90] total_changed
  output logic [95:0]                    out_tdata,

  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  // Configuration registers.
  logic [dpm_pkg::TIME_BITS-1:0] filter_time_us_r;
  logic [dpm_pkg::TIME_BITS-1:0] timeout_time_us_r;

  // Handshake and pipeline control.
  logic in_take;
  logic mid_adv;
  logic out_adv;
  logic mid_valid_r, mid_valid_nxt;
  logic out_valid_r, out_valid_nxt;

  dpm_pkg::track_res_t track_res;
  dpm_pkg::track_res_t mid_r;

  // Millisecond stage.
  logic [dpm_pkg::MS_PROD_W-1:0]   ms_prod;
  logic [dpm_pkg::PERIOD_MS_W-1:0] period_ms;
  logic                            period_chg;
  logic [dpm_pkg::PERIOD_MS_W-1:0] reported_ms_r;
  logic                            period_once_r;
  logic                            ms_report;

  // Output register fields.
  logic                            out_accepted_r;
  logic                            out_timed_out_r;
  logic [dpm_pkg::TIME_BITS-1:0]   out_period_us_r;
  logic [dpm_pkg::PERIOD_MS_W-1:0] out_period_ms_r;
  logic [dpm_pkg::COUNT_BITS-1:0]  out_total_r;
  logic                            out_period_chg_r;
  logic                            out_total_chg_r;

  // --------------------------------------------------------------------------
  // Configuration port: always ready, one register per transfer.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_time_us_r  <= dpm_pkg::FILTER_RESET;
      timeout_time_us_r <= dpm_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dpm_pkg::CFG_FILTER:  filter_time_us_r  <= cfg_data;
        dpm_pkg::CFG_TIMEOUT: timeout_time_us_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. A stage moves on when the stage after it is empty or is
  // itself moving on, so the pipeline fills without bubbles.
  // --------------------------------------------------------------------------
  always_comb begin
    out_adv   = !out_valid_r || out_tready;
    mid_adv   = !mid_valid_r || out_adv;
    in_tready = mid_adv;
    in_take   = in_tvalid && mid_adv;

    mid_valid_nxt = mid_adv ? in_take : mid_valid_r;
    out_valid_nxt = out_adv ? mid_valid_r : out_valid_r;
    ms_report     = out_adv && mid_valid_r && mid_r.is_tick;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mid_valid_r <= mid_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // First stage: the tracking state is updated at the transfer itself, and
  // the item's result fields are captured in the middle register.
  // --------------------------------------------------------------------------
  dpm_track u_track (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (in_take),
    .is_tick         (in_tuser == dpm_pkg::OP_TICK),
    .pin_level       (in_tdata[0]),
    .time_us         (in_tdata[32:1]),
    .filter_time_us  (filter_time_us_r),
    .timeout_time_us (timeout_time_us_r),
    .res             (track_res)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      mid_r <= track_res;
    end
  end

  // --------------------------------------------------------------------------
  // Second stage: period in milliseconds and its change flag. The reported
  // value follows ticks in order, since results leave this stage in order.
  // --------------------------------------------------------------------------
  always_comb begin
    ms_prod    = dpm_pkg::MS_PROD_W'(mid_r.period_us) *
                 dpm_pkg::MS_PROD_W'(dpm_pkg::MS_MAGIC);
    period_ms  = dpm_pkg::PERIOD_MS_W'(ms_prod >> dpm_pkg::MS_SHIFT);
    period_chg = mid_r.is_tick && (!period_once_r || (period_ms != reported_ms_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reported_ms_r <= '0;
      period_once_r <= 1'b0;
    end else if (ms_report) begin
      reported_ms_r <= period_ms;
      period_once_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && mid_valid_r) begin
      out_accepted_r   <= mid_r.edge_accepted;
      out_timed_out_r  <= mid_r.timed_out;
      out_period_us_r  <= mid_r.period_us;
      out_period_ms_r  <= period_ms;
      out_total_r      <= mid_r.pulse_total;
      out_period_chg_r <= period_chg;
      out_total_chg_r  <= mid_r.total_changed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_total_chg_r, out_period_chg_r, out_total_r,
                       out_period_ms_r, out_period_us_r, out_timed_out_r,
                       out_accepted_r};

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------
  // The input side only stalls when both pipeline registers are occupied.
  `DPM_ASSERT_IMPLY(a_stall_full, !in_tready, mid_valid_r && out_valid_r && !out_tready)
  // An edge result never carries the tick-only change flag.
  `DPM_ASSERT_IMPLY(a_edge_no_tchg, mid_valid_r && !mid_r.is_tick, !mid_r.total_changed)
  // A timeout clears the period, so both period fields read zero.
  `DPM_ASSERT_IMPLY(a_tmo_clears, out_valid_r && out_timed_out_r,
                    out_period_us_r == '0 && out_period_ms_r == '0 && !out_accepted_r)
  // After a tick leaves the second stage a first report has been made.
  `DPM_ASSERT_NEXT(a_reported_once, ms_report, period_once_r && reported_ms_r == out_period_ms_r)

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for the debounced pulse period meter
// Drives pin edges and poll ticks through the input stream, rewrites the
// filter and timeout registers between phases, and checks every result
// transfer against a cycle-free model of the meter kept in a scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Two pipeline stages, plus a little margin, before the meter is idle.
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [dpm_pkg::TIME_BITS-1:0] US_PER_MS = dpm_pkg::TIME_BITS'(1000);

  // One input item: the opcode travels on in_tuser, the rest on in_tdata.
  typedef struct {
    dpm_pkg::opcode_t              op;
    logic                          level;
    logic [dpm_pkg::TIME_BITS-1:0] stamp;
  } meter_item_t;

  // Laid out so that the first member sits in the top bits, which matches
  // out_tdata[90:0] from the total change flag down to the acceptance flag.
  typedef struct packed {
    logic                            total_changed;
    logic                            period_changed;
    logic [dpm_pkg::COUNT_BITS-1:0]  pulse_total;
    logic [dpm_pkg::PERIOD_MS_W-1:0] period_ms;
    logic [dpm_pkg::TIME_BITS-1:0]   period_us;
    logic                            timed_out;
    logic                            edge_accepted;
  } meter_reading_t;

  // Tracks what the meter should hold and report, and checks its readings.
  class pulse_meter_tracker;
    logic [dpm_pkg::TIME_BITS-1:0]   filter_gap;
    logic [dpm_pkg::TIME_BITS-1:0]   timeout_gap;
    logic [dpm_pkg::TIME_BITS-1:0]   last_detect;
    logic [dpm_pkg::TIME_BITS-1:0]   valid_since;
    logic [dpm_pkg::TIME_BITS-1:0]   period_us;
    logic [dpm_pkg::COUNT_BITS-1:0]  pulses;
    logic [dpm_pkg::PERIOD_MS_W-1:0] shown_ms;
    logic                            ms_shown;
    logic [dpm_pkg::COUNT_BITS-1:0]  shown_total;
    logic                            total_shown;
    meter_reading_t                  expected_readings[$];
    int unsigned                     faults;
    int unsigned                     checked;
    int unsigned                     ticks;
    int unsigned                     accepted;
    int unsigned                     timeouts;
    int unsigned                     writes;

    function new();
      filter_gap  = dpm_pkg::FILTER_RESET;
      timeout_gap = dpm_pkg::TIMEOUT_RESET;
      last_detect = '0;
      valid_since = '0;
      period_us   = '0;
      pulses      = '0;
      shown_ms    = '0;
      ms_shown    = 1'b0;
      shown_total = '0;
      total_shown = 1'b0;
      faults      = 0;
      checked     = 0;
      ticks       = 0;
      accepted    = 0;
      timeouts    = 0;
      writes      = 0;
    endfunction

    function void set_register(dpm_pkg::cfg_idx_t idx, logic [31:0] value);
      writes++;
      if (idx == dpm_pkg::CFG_FILTER) begin
        filter_gap = value;
      end else begin
        timeout_gap = value;
      end
    endfunction

    // Advances the meter state by one item and returns the reading it gives.
    function meter_reading_t predict_reading(meter_item_t item);
      meter_reading_t r;
      r = '0;
      if (item.op == dpm_pkg::OP_EDGE) begin
        // Falling edges leave everything untouched.
        if (item.level) begin
          if (dpm_pkg::TIME_BITS'(item.stamp - last_detect) >= filter_gap) begin
            // A held timestamp of zero means no valid edge, so no period.
            if (valid_since != '0) begin
              period_us = dpm_pkg::TIME_BITS'(item.stamp - valid_since);
            end
            pulses          = pulses + 1'b1;
            valid_since     = item.stamp;
            r.edge_accepted = 1'b1;
            accepted++;
          end
          // Even a rejected rising edge restarts the filter window.
          last_detect = item.stamp;
        end
      end else begin
        ticks++;
        if (valid_since != '0 &&
            dpm_pkg::TIME_BITS'(item.stamp - valid_since) > timeout_gap) begin
          valid_since = '0;
          period_us   = '0;
          r.timed_out = 1'b1;
          timeouts++;
        end
      end
      r.period_us   = period_us;
      r.period_ms   = dpm_pkg::PERIOD_MS_W'(period_us / US_PER_MS);
      r.pulse_total = pulses;
      if (item.op == dpm_pkg::OP_TICK) begin
        r.period_changed = !ms_shown || r.period_ms != shown_ms;
        shown_ms         = r.period_ms;
        ms_shown         = 1'b1;
        r.total_changed  = !total_shown || pulses != shown_total;
        shown_total      = pulses;
        total_shown      = 1'b1;
      end
      return r;
    endfunction

    function void note_transfer(meter_item_t item);
      expected_readings.push_back(predict_reading(item));
    endfunction

    function string describe(meter_reading_t r);
      return $sformatf("acc=%0b tmo=%0b us=%0d ms=%0d total=%0d pchg=%0b tchg=%0b",
                       r.edge_accepted, r.timed_out, r.period_us, r.period_ms,
                       r.pulse_total, r.period_changed, r.total_changed);
    endfunction

    function void check_reading(meter_reading_t got);
      meter_reading_t want;
      string          bad;
      if (expected_readings.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT) begin
          $display("reading with nothing expected: %s", describe(got));
        end
        return;
      end
      want = expected_readings.pop_front();
      checked++;
      bad = "";
      if (got.edge_accepted !== want.edge_accepted) bad = {bad, " edge_accepted"};
      if (got.timed_out !== want.timed_out) bad = {bad, " timed_out"};
      if (got.period_us !== want.period_us) bad = {bad, " period_us"};
      if (got.period_ms !== want.period_ms) bad = {bad, " period_ms"};
      if (got.pulse_total !== want.pulse_total) bad = {bad, " pulse_total"};
      if (got.period_changed !== want.period_changed) bad = {bad, " period_changed"};
      if (got.total_changed !== want.total_changed) bad = {bad, " total_changed"};
      if (bad != "") begin
        faults++;
        if (faults <= REPORT_LIMIT) begin
          $display("reading %0d wrong in%s", checked, bad);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [39:0]                   in_tdata   = '0;
  logic                          in_tuser   = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [95:0]                   out_tdata;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [dpm_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [31:0]                   cfg_data   = '0;

  logic [15:0]                   ready_pattern = 16'hFFFF;
  logic [3:0]                    stall_idx     = '0;
  int unsigned                   cycle_count   = 0;
  int unsigned                   burst_left    = 0;
  int unsigned                   items_sent    = 0;

  pulse_meter_tracker            tracker;

  always #5 clk = ~clk;

  debounced_pulse_period_meter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Result side. The values read here are those from before the edge, so a
  // transfer is seen exactly when the meter sees it. Back-pressure follows
  // a rotating sixteen-bit pattern that changes from phase to phase.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_reading(meter_reading_t'(out_tdata[90:0]));
    end
    out_tready <= rst_n & ready_pattern[stall_idx];
    stall_idx  <= stall_idx + 4'd1;
  end

  // Watchdog: a run that stalls or loses results ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Presents one item and holds it until the meter takes it. Returns at the
  // edge of the transfer, so the caller may drive the next item straight away.
  task automatic transfer_item(dpm_pkg::opcode_t op, logic level,
                               logic [dpm_pkg::TIME_BITS-1:0] stamp);
    meter_item_t item;
    item.op    = op;
    item.level = level;
    item.stamp = stamp;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, stamp, level};
    do @(posedge clk); while (!in_tready);
    tracker.note_transfer(item);
    items_sent++;
  endtask

  // Lowers the input valid and waits until every result has come back and
  // the pipeline has had time to empty, so that the registers may be changed.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back, keeping valid high between them.
  task automatic configure(logic [31:0] flt_val, logic [31:0] tmo_val);
    cfg_valid <= 1'b1;
    cfg_index <= dpm_pkg::CFG_FILTER;
    cfg_data  <= flt_val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(dpm_pkg::CFG_FILTER, flt_val);
    cfg_index <= dpm_pkg::CFG_TIMEOUT;
    cfg_data  <= tmo_val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(dpm_pkg::CFG_TIMEOUT, tmo_val);
    cfg_valid <= 1'b0;
  endtask

  // Chooses the next timestamp so that it often lands right on, or just
  // either side of, the filter and timeout boundaries, with wraps and jumps
  // to zero mixed in.
  function automatic logic [dpm_pkg::TIME_BITS-1:0] pick_stamp(
      logic [dpm_pkg::TIME_BITS-1:0] prev);
    case ($urandom_range(0, 11))
      0:       return prev;
      1:       return prev + $urandom_range(1, 50);
      2:       return tracker.last_detect + tracker.filter_gap - 1'b1;
      3:       return tracker.last_detect + tracker.filter_gap;
      4:       return tracker.last_detect + tracker.filter_gap + $urandom_range(1, 1000);
      5:       return tracker.valid_since + tracker.timeout_gap;
      6:       return tracker.valid_since + tracker.timeout_gap + 1'b1;
      7:       return $urandom;
      8:       return '0;
      default: return prev + (tracker.filter_gap >> $urandom_range(0, 3)) +
                      $urandom_range(0, 999);
    endcase
  endfunction

  // One phase of random traffic under a given register setting. The sender
  // works in bursts separated by idle gaps whose length is at most gap_max.
  task automatic run_phase(logic [31:0] flt_val, logic [31:0] tmo_val,
                           int unsigned count, int unsigned gap_max,
                           logic [15:0] stall_pattern);
    logic [dpm_pkg::TIME_BITS-1:0] now;
    dpm_pkg::opcode_t              op;
    logic                          level;
    int unsigned                   gap;
    configure(flt_val, tmo_val);
    // Bit zero is always set so that the result side can never lock up.
    ready_pattern <= stall_pattern | 16'h0001;
    now        = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom;
    burst_left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      op    = ($urandom_range(0, 99) < 30) ? dpm_pkg::OP_TICK : dpm_pkg::OP_EDGE;
      level = ($urandom_range(0, 99) < 85);
      now   = pick_stamp(now);
      transfer_item(op, level, now);
    end
    settle();
  endtask

  initial begin
    tracker = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening under the reset register values.
    ready_pattern <= 16'hB6DB;
    transfer_item(dpm_pkg::OP_TICK, 1'b0, 32'd0);          // first report flags both changes
    transfer_item(dpm_pkg::OP_TICK, 1'b0, 32'd5);          // nothing changed since then
    transfer_item(dpm_pkg::OP_EDGE, 1'b0, 32'd200000);     // falling edge is ignored
    transfer_item(dpm_pkg::OP_EDGE, 1'b1, 32'd50000);      // too soon, but restarts the window
    transfer_item(dpm_pkg::OP_EDGE, 1'b1, 32'd150000);     // exactly the filter time: accepted
    transfer_item(dpm_pkg::OP_EDGE, 1'b1, 32'd300000);     // first measured period
    transfer_item(dpm_pkg::OP_TICK, 1'b0, 32'd300001);
    transfer_item(dpm_pkg::OP_EDGE, 1'b1, 32'd0);          // wraps, and zero is held as none
    transfer_item(dpm_pkg::OP_EDGE, 1'b1, 32'd200000);     // no period after a zero stamp
    transfer_item(dpm_pkg::OP_EDGE, 1'b1, 32'hFFFF_FFFF);
    transfer_item(dpm_pkg::OP_TICK, 1'b0, 32'd299999999);  // exactly the timeout: kept
    transfer_item(dpm_pkg::OP_TICK, 1'b0, 32'd300000000);  // one past it: cleared
    transfer_item(dpm_pkg::OP_TICK, 1'b0, 32'd300000001);  // no valid edge held
    transfer_item(dpm_pkg::OP_TICK, 1'b1, 32'h8000_0000);  // level is ignored on a tick
    transfer_item(dpm_pkg::OP_EDGE, 1'b1, 32'h7FFF_FFFF);
    transfer_item(dpm_pkg::OP_TICK, 1'b0, 32'hFFFF_FFFE);
    settle();

    // Random phases over a spread of register settings, extremes included.
    run_phase(32'd0, 32'd0, 75, 0, 16'hFFFF);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 75, 6, $urandom);
    run_phase(dpm_pkg::FILTER_RESET, dpm_pkg::TIMEOUT_RESET, 75, 3, 16'h00FF);
    run_phase(32'd1000, 32'd5000, 75, 8, 16'hAAAA);
    run_phase($urandom_range(1, 200000), $urandom_range(1, 2000000), 75, 4, $urandom);
    run_phase($urandom, $urandom, 75, 2, 16'hFFFF);
    run_phase($urandom_range(0, 50), $urandom_range(0, 500), 75, 5, $urandom);
    run_phase(32'd100, 32'hFFFF_FFFF, 75, 0, 16'hF0F0);

    $display("run covered %0d items: %0d poll ticks, %0d accepted edges, %0d timeouts",
             items_sent, tracker.ticks, tracker.accepted, tracker.timeouts);
    $display("%0d register writes, %0d readings checked, %0d faults",
             tracker.writes, tracker.checked, tracker.faults);
    if (tracker.faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+design
design/dpm_pkg.sv
design/dpm_track.sv
design/debounced_pulse_period_meter.sv
sim/testbench.sv
